/* rtl/wss_pkg.sv */
// shared types and constants of the wildcard substring search unit
package wss_pkg;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  // register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [1:0] REG_WILDCARD_MASK  = 2'd1;
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

  localparam logic [7:0]  DOT_BYTE  = 8'h2E;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int QDEPTH      = 4;

  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [7:0]  wildcard_mask;
    logic [3:0]  pattern_length;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] position;
    logic [3:0]  length;
    logic [15:0] count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

/* rtl/wildcard_substring_search_unit.sv */
// top level of the wildcard substring search unit
//
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  tdata[7:0] src_byte, tlast is_last
//  m_*      out        m_tvalid/m_tready  tdata position/length/count,
//                                         tuser result_kind, tlast last_result
//  apb      in         psel/penable       pattern_bytes @0x00, wildcard_mask @0x08,
//                                         pattern_length @0x10
//
// one source byte per cycle while s_tready is high: the compare of the shifted
// window against the masked pattern and the counter updates sit between the
// source transfer and the result queue, so a byte's results are in the queue
// the cycle after it. a byte gives up to two results (match, then summary on
// the last byte); the queue sends one per cycle while m_tready is high.
// s_tready is high while the queue has room for two results, so a stall on
// the output side reaches the input once three results are queued.
// synchronous reset clears the counters, the queue and the registers
// (pattern length back to 1).
module wildcard_substring_search_unit #(
  parameter int MAX_PATTERN   = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // stream in
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [wss_pkg::IN_TDATA_W-1:0]     s_tdata,  // [7:0] src_byte
  input  logic                               s_tlast,
  // stream out
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [15:0] match_position, [19:16] match_length, [35:20] match_count, rest zero
  output logic [wss_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tuser,  // [0] result_kind
  output logic                               m_tlast,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wss_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [wss_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [wss_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import wss_pkg::*;

  cfg_t  cfg;
  push_t push;
  res_t  head;
  logic  space;
  logic  accept;

  assign s_tready = space;
  assign accept   = s_tvalid && s_tready;

  wss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wss_match #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_match (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .src_byte (s_tdata[7:0]),
    .is_last  (s_tlast),
    .push     (push)
  );

  // queue output is the result register
  wss_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .head      (head)
  );

  assign m_tdata = {4'd0, head.count, head.length, head.position};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

/* rtl/wss_cfg.sv */
// configuration registers behind the apb-style port
module wss_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wss_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [wss_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [wss_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output wss_pkg::cfg_t                    cfg
);
  import wss_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_bytes  <= '0;
      cfg.wildcard_mask  <= '0;
      cfg.pattern_length <= 4'd1;
    end else if (wr_en) begin
      case (reg_sel)
        REG_PATTERN_BYTES:  cfg.pattern_bytes  <= pwdata;
        REG_WILDCARD_MASK:  cfg.wildcard_mask  <= pwdata[7:0];
        REG_PATTERN_LENGTH: cfg.pattern_length <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PATTERN_BYTES:  prdata = cfg.pattern_bytes;
      REG_WILDCARD_MASK:  prdata = {56'd0, cfg.wildcard_mask};
      REG_PATTERN_LENGTH: prdata = {60'd0, cfg.pattern_length};
      default:            prdata = '0;
    endcase
  end

endmodule

/* rtl/wss_match.sv */
// byte window, pattern compare and per-string counters
module wss_match #(
  parameter int MAX_PATTERN   = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  wss_pkg::cfg_t  cfg,
  input  logic           accept,
  input  logic [7:0]     src_byte,
  input  logic           is_last,
  output wss_pkg::push_t push
);
  import wss_pkg::*;

  localparam int WIN_IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic [7:0]               window [MAX_PATTERN];
  logic [7:0]               window_next [MAX_PATTERN];
  logic [FILL_W-1:0]        fill;
  logic [FILL_W-1:0]        fill_inc;
  logic [POSITION_BITS-1:0] byte_index;
  logic [POSITION_BITS-1:0] index_inc;
  logic [15:0]              found_count;
  logic [15:0]              count_inc;
  logic [3:0]               len_used;
  logic                     hit;
  logic                     matched;
  logic [POSITION_BITS-1:0] pos;
  logic [31:0]              pos_wide;
  res_t                     match_res;
  res_t                     summary_res;

  always_comb begin
    window_next[0] = src_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_next[k] = window[k-1];
    end
  end

  assign len_used  = (cfg.pattern_length > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN)
                                                            : cfg.pattern_length;
  assign fill_inc  = (fill < FILL_W'(MAX_PATTERN)) ? fill + 1'b1 : fill;
  assign index_inc = (byte_index < POS_MAX) ? byte_index + 1'b1 : byte_index;

  // pattern position i lines up with window entry len-1-i
  always_comb begin
    logic [WIN_IW-1:0] idx;
    logic [7:0]        pat;
    logic              any;
    hit = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      idx = WIN_IW'(len_used - 4'd1 - 4'(i));
      pat = cfg.pattern_bytes[8*i +: 8];
      any = cfg.wildcard_mask[i] || (pat == DOT_BYTE);
      if ((4'(i) < len_used) && !any && (window_next[idx] != pat)) begin
        hit = 1'b0;
      end
    end
  end

  assign matched   = (len_used != 4'd0) && (4'(fill_inc) >= len_used) && hit;
  assign pos       = (byte_index >= POS_MAX) ? POS_MAX
                   : byte_index - POSITION_BITS'(len_used - 4'd1);
  assign pos_wide  = 32'(pos);
  assign count_inc = (matched && (found_count != COUNT_MAX)) ? found_count + 16'd1
                                                             : found_count;

  always_comb begin
    match_res.kind     = KIND_MATCH;
    match_res.position = pos_wide[15:0];
    match_res.length   = len_used;
    match_res.count    = count_inc;
    match_res.last     = !is_last;

    summary_res.kind     = KIND_SUMMARY;
    summary_res.position = '0;
    summary_res.length   = '0;
    summary_res.count    = count_inc;
    summary_res.last     = 1'b1;

    push.num = '0;
    push.r0  = summary_res;
    push.r1  = summary_res;
    if (accept) begin
      push.num = 2'(matched) + 2'(is_last);
      if (matched) begin
        push.r0 = match_res;
      end
    end
  end

  // window data is only compared inside the fill, so it needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        window[k] <= window_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      byte_index  <= '0;
      found_count <= '0;
    end else if (accept) begin
      if (is_last) begin
        fill        <= '0;
        byte_index  <= '0;
        found_count <= '0;
      end else begin
        fill        <= matched ? '0 : fill_inc;
        byte_index  <= index_inc;
        found_count <= count_inc;
      end
    end
  end

endmodule

/* rtl/wss_outq.sv */
// small result queue, takes up to two results per transfer and sends one
module wss_outq (
  input  logic           clk,
  input  logic           rst,
  input  wss_pkg::push_t push,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output wss_pkg::res_t  head
);
  import wss_pkg::*;

  localparam int CNT_W = $clog2(QDEPTH + 1);

  res_t             q [QDEPTH];
  res_t             q_next [QDEPTH];
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_after;
  logic [CNT_W-1:0] cnt_next;
  logic             pop;

  assign out_valid = (cnt != '0);
  assign head      = q[0];
  assign space     = (cnt <= CNT_W'(QDEPTH - 2));
  assign pop       = out_valid && out_ready;
  assign cnt_after = cnt - CNT_W'(pop);
  assign cnt_next  = cnt_after + CNT_W'(push.num);

  always_comb begin
    for (int j = 0; j < QDEPTH; j++) begin
      if (pop) begin
        q_next[j] = (j < QDEPTH - 1) ? q[(j + 1) % QDEPTH] : q[j];
      end else begin
        q_next[j] = q[j];
      end
      if ((push.num != 2'd0) && (CNT_W'(j) == cnt_after)) begin
        q_next[j] = push.r0;
      end
      if ((push.num == 2'd2) && (CNT_W'(j) == cnt_after + 1'b1)) begin
        q_next[j] = push.r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QDEPTH; j++) begin
      q[j] <= q_next[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

/* rtl/wss_checker.sv */
// port-level checks of the wildcard substring search unit, bound to the top
module wss_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [wss_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tuser,
  input logic                            m_tlast
);
  import wss_pkg::*;

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result offered after reset");

  // a summary closes the byte's results and has no position or length
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_SUMMARY) |-> m_tlast && (m_tdata[19:0] == 20'd0))
    else $error("malformed summary");

  // a match always has a nonzero length and count
  a_match_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_MATCH) |-> (m_tdata[19:16] != 4'd0) &&
                                            (m_tdata[35:20] != 16'd0))
    else $error("malformed match");

endmodule

bind wildcard_substring_search_unit wss_checker u_wss_checker (.*);
